// File: hdl/lfu_pkg.sv
// ----------------------------------------------------------------------------
// lfu_pkg
// Shared types, constants and helpers for the LFU page replacement unit.
// ----------------------------------------------------------------------------
package lfu_pkg;

  // Default sizing
  localparam int NUM_FRAMES_DEF = 16;
  localparam int PAGE_BITS_DEF  = 16;

  // Fixed field widths
  localparam int PAGE_ID_W   = 16;
  localparam int CNT_W       = 32;
  localparam int CFG_W       = 5;
  localparam int IN_TDATA_W  = 16;
  localparam int OUT_TDATA_W = 80;
  localparam int OUT_TUSER_W = 2;

  // Bit positions in out_tuser
  localparam int TUSER_HIT = 0;
  localparam int TUSER_EVV = 1;

  localparam logic [CFG_W-1:0] CFG_RESET = 5'd16;
  localparam logic [CNT_W-1:0] CNT_MAX   = 32'hFFFF_FFFF;
  localparam logic [CNT_W-1:0] CNT_ONE   = 32'd1;

  // Controller states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_LAST,
    ST_COMMIT
  } lfu_state_t;

  // Controller -> datapath
  typedef struct packed {
    logic accept;   // latch new reference, clear scan trackers
    logic issue;    // read one frame, advance scan address
    logic commit;   // write frame, update totals, load result
  } lfu_cmd_t;

  // Datapath -> controller
  typedef struct packed {
    logic issue_last;  // current scan address is the last active frame
    logic out_free;    // result register can take a new item
  } lfu_sts_t;

  // Saturating increment for use counts and totals
  function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
    return (v == CNT_MAX) ? v : v + CNT_ONE;
  endfunction

endpackage

// File: hdl/lfu_ram.sv
// ----------------------------------------------------------------------------
// lfu_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module lfu_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                  clk,
  input  logic                                  we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                      wdata,
  input  logic                                  re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                      rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// File: hdl/lfu_ctrl.sv
// ----------------------------------------------------------------------------
// lfu_ctrl
// Sequencer: accept a reference, scan active frames, then commit the result.
// ----------------------------------------------------------------------------
module lfu_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  lfu_pkg::lfu_sts_t sts,
  output lfu_pkg::lfu_cmd_t cmd
);

  lfu_pkg::lfu_state_t state_r, state_nxt;

  // State register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= lfu_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_tready = 1'b0;
    unique case (state_r)
      lfu_pkg::ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.accept = 1'b1;
          state_nxt  = lfu_pkg::ST_SCAN;
        end
      end
      lfu_pkg::ST_SCAN: begin
        cmd.issue = 1'b1;
        if (sts.issue_last) begin
          state_nxt = lfu_pkg::ST_LAST;
        end
      end
      // last frame's read data is evaluated here
      lfu_pkg::ST_LAST: begin
        state_nxt = lfu_pkg::ST_COMMIT;
      end
      lfu_pkg::ST_COMMIT: begin
        if (sts.out_free) begin
          cmd.commit = 1'b1;
          state_nxt  = lfu_pkg::ST_IDLE;
        end
      end
    endcase
  end

endmodule

// File: hdl/lfu_dpath.sv
// ----------------------------------------------------------------------------
// lfu_dpath
// Frame store, scan trackers (hit, empty slot, LFU victim), totals and result.
// ----------------------------------------------------------------------------
module lfu_dpath #(
  parameter int NUM_FRAMES = lfu_pkg::NUM_FRAMES_DEF,
  parameter int PAGE_BITS  = lfu_pkg::PAGE_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  lfu_pkg::lfu_cmd_t               cmd,
  output lfu_pkg::lfu_sts_t               sts,
  input  logic [lfu_pkg::IN_TDATA_W-1:0]  in_tdata,
  input  logic                            cfg_valid,
  input  logic [lfu_pkg::CFG_W-1:0]       cfg_data,
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [lfu_pkg::OUT_TDATA_W-1:0] out_tdata,
  output logic [lfu_pkg::OUT_TUSER_W-1:0] out_tuser
);

  localparam int PG_W  = (PAGE_BITS < lfu_pkg::PAGE_ID_W) ? PAGE_BITS : lfu_pkg::PAGE_ID_W;
  localparam int FW    = (NUM_FRAMES > 1) ? $clog2(NUM_FRAMES) : 1;
  localparam int CW    = $clog2(NUM_FRAMES + 1);
  localparam int NW    = (CW > lfu_pkg::CFG_W) ? CW : lfu_pkg::CFG_W;
  localparam int CNT_W = lfu_pkg::CNT_W;
  localparam int WORD_W = PG_W + 2 * CNT_W;

  // Configuration register
  logic [lfu_pkg::CFG_W-1:0] cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= lfu_pkg::CFG_RESET;
    end else if (cfg_valid) begin
      cfg_r <= cfg_data;
    end
  end

  // Active frame count, clamped to 1..NUM_FRAMES
  logic [NW-1:0] cfg_w;
  logic [CW-1:0] n_act;

  always_comb begin
    cfg_w = NW'(cfg_r);
    if (cfg_w == '0) begin
      n_act = CW'(1);
    end else if (cfg_w > NW'(NUM_FRAMES)) begin
      n_act = CW'(NUM_FRAMES);
    end else begin
      n_act = CW'(cfg_w);
    end
  end

  // Reference latch and scan address
  logic [PG_W-1:0] pg_r;
  logic [FW-1:0]   addr_r;
  logic [FW-1:0]   idx_r;
  logic            rd_vld_r;

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      pg_r <= PG_W'(in_tdata);
    end
    if (cmd.accept) begin
      addr_r <= '0;
    end else if (cmd.issue) begin
      addr_r <= addr_r + FW'(1);
    end
    if (cmd.issue) begin
      idx_r <= addr_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_vld_r <= 1'b0;
    end else begin
      rd_vld_r <= cmd.issue;
    end
  end

  assign sts.issue_last = (CW'(addr_r) == (n_act - CW'(1)));

  // Frame store: {load index, use count, page}
  logic              ram_we;
  logic [FW-1:0]     ram_waddr;
  logic [WORD_W-1:0] ram_wdata;
  logic [WORD_W-1:0] ram_rdata;

  lfu_ram #(
    .WIDTH (WORD_W),
    .DEPTH (NUM_FRAMES)
  ) u_frames (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (cmd.issue),
    .raddr (addr_r),
    .rdata (ram_rdata)
  );

  logic [PG_W-1:0]  rd_page;
  logic [CNT_W-1:0] rd_cnt;
  logic [CNT_W-1:0] rd_ld;

  assign rd_page = ram_rdata[PG_W-1:0];
  assign rd_cnt  = ram_rdata[PG_W +: CNT_W];
  assign rd_ld   = ram_rdata[PG_W + CNT_W +: CNT_W];

  // Valid bits, cleared at reset
  logic [NUM_FRAMES-1:0] valid_r;
  logic                  rd_valid;

  assign rd_valid = valid_r[idx_r];

  // Scan trackers
  logic             found_r,  found_nxt;
  logic [FW-1:0]    fnd_idx_r, fnd_idx_nxt;
  logic [CNT_W-1:0] fnd_cnt_r, fnd_cnt_nxt;
  logic [CNT_W-1:0] fnd_ld_r,  fnd_ld_nxt;
  logic             empty_r,  empty_nxt;
  logic [FW-1:0]    emp_idx_r, emp_idx_nxt;
  logic             vic_r,    vic_nxt;
  logic [FW-1:0]    vic_idx_r, vic_idx_nxt;
  logic [CNT_W-1:0] vic_cnt_r, vic_cnt_nxt;
  logic [CNT_W-1:0] vic_ld_r,  vic_ld_nxt;
  logic [PG_W-1:0]  vic_pg_r,  vic_pg_nxt;

  // Evaluate one returned frame per cycle
  always_comb begin
    found_nxt   = found_r;
    fnd_idx_nxt = fnd_idx_r;
    fnd_cnt_nxt = fnd_cnt_r;
    fnd_ld_nxt  = fnd_ld_r;
    empty_nxt   = empty_r;
    emp_idx_nxt = emp_idx_r;
    vic_nxt     = vic_r;
    vic_idx_nxt = vic_idx_r;
    vic_cnt_nxt = vic_cnt_r;
    vic_ld_nxt  = vic_ld_r;
    vic_pg_nxt  = vic_pg_r;
    if (cmd.accept) begin
      found_nxt = 1'b0;
      empty_nxt = 1'b0;
      vic_nxt   = 1'b0;
    end else if (rd_vld_r) begin
      if (rd_valid) begin
        // first resident match
        if (!found_r && rd_page == pg_r) begin
          found_nxt   = 1'b1;
          fnd_idx_nxt = idx_r;
          fnd_cnt_nxt = rd_cnt;
          fnd_ld_nxt  = rd_ld;
        end
        // strictly smaller (count, load index) wins; ties keep lower frame
        if (!vic_r || rd_cnt < vic_cnt_r ||
            (rd_cnt == vic_cnt_r && rd_ld < vic_ld_r)) begin
          vic_nxt     = 1'b1;
          vic_idx_nxt = idx_r;
          vic_cnt_nxt = rd_cnt;
          vic_ld_nxt  = rd_ld;
          vic_pg_nxt  = rd_page;
        end
      end else if (!empty_r) begin
        empty_nxt   = 1'b1;
        emp_idx_nxt = idx_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      found_r <= 1'b0;
      empty_r <= 1'b0;
      vic_r   <= 1'b0;
    end else begin
      found_r <= found_nxt;
      empty_r <= empty_nxt;
      vic_r   <= vic_nxt;
    end
  end

  always_ff @(posedge clk) begin
    fnd_idx_r <= fnd_idx_nxt;
    fnd_cnt_r <= fnd_cnt_nxt;
    fnd_ld_r  <= fnd_ld_nxt;
    emp_idx_r <= emp_idx_nxt;
    vic_idx_r <= vic_idx_nxt;
    vic_cnt_r <= vic_cnt_nxt;
    vic_ld_r  <= vic_ld_nxt;
    vic_pg_r  <= vic_pg_nxt;
  end

  // Commit: frame write and result values
  logic [CNT_W-1:0] ref_idx_r;
  logic [CNT_W-1:0] hit_tot_r, fault_tot_r;
  logic [CNT_W-1:0] hit_tot_nxt, fault_tot_nxt;
  logic             ev_valid;
  logic [lfu_pkg::PAGE_ID_W-1:0] ev_page;

  always_comb begin
    ram_we        = cmd.commit;
    hit_tot_nxt   = hit_tot_r;
    fault_tot_nxt = fault_tot_r;
    ev_valid      = 1'b0;
    ev_page       = '0;
    if (found_r) begin
      ram_waddr   = fnd_idx_r;
      ram_wdata   = {fnd_ld_r, lfu_pkg::sat_inc(fnd_cnt_r), pg_r};
      hit_tot_nxt = lfu_pkg::sat_inc(hit_tot_r);
    end else begin
      ram_waddr     = empty_r ? emp_idx_r : vic_idx_r;
      ram_wdata     = {ref_idx_r, lfu_pkg::CNT_ONE, pg_r};
      fault_tot_nxt = lfu_pkg::sat_inc(fault_tot_r);
      if (!empty_r) begin
        ev_valid = 1'b1;
        ev_page  = lfu_pkg::PAGE_ID_W'(vic_pg_r);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r     <= '0;
      ref_idx_r   <= '0;
      hit_tot_r   <= '0;
      fault_tot_r <= '0;
    end else if (cmd.commit) begin
      valid_r[ram_waddr] <= 1'b1;
      ref_idx_r          <= ref_idx_r + lfu_pkg::CNT_ONE;
      hit_tot_r          <= hit_tot_nxt;
      fault_tot_r        <= fault_tot_nxt;
    end
  end

  // Result register
  logic                            out_vld_r;
  logic [lfu_pkg::OUT_TDATA_W-1:0] out_data_r;
  logic [lfu_pkg::OUT_TUSER_W-1:0] out_user_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (cmd.commit) begin
      out_vld_r <= 1'b1;
    end else if (out_tready) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      out_data_r <= {fault_tot_nxt, hit_tot_nxt, ev_page};
      out_user_r <= {ev_valid, found_r};
    end
  end

  assign sts.out_free = !out_vld_r || out_tready;
  assign out_tvalid   = out_vld_r;
  assign out_tdata    = out_data_r;
  assign out_tuser    = out_user_r;

endmodule

// File: hdl/lfu_page_replacement_unit.sv
// ----------------------------------------------------------------------------
// lfu_page_replacement_unit
// Least-frequently-used page replacement over a RAM-backed frame table.
// ----------------------------------------------------------------------------
//
//  channel | dir | signals                        | content
//  --------+-----+--------------------------------+-----------------------------
//  in      | in  | in_tvalid/tready/tdata[15:0]   | page_id
//  out     | out | out_tvalid/tready/tdata[79:0]  | evicted_page, hit_count,
//          |     | out_tuser[1:0]                 | fault_count; hit, evicted_valid
//  cfg     | in  | cfg_valid/ready/data[4:0]      | frames_in_use
//
//  An item passes through accept, a scan with one frame table read per cycle
//  over the N active frames, a wait for the last read to return, and commit.
//  Reset (rst_n low, synchronous) empties all frames and clears the totals.
//  A stalled result holds in the output register; the next item is accepted
//  meanwhile and waits in commit until the output register frees.
// ----------------------------------------------------------------------------
module lfu_page_replacement_unit #(
  parameter int NUM_FRAMES = lfu_pkg::NUM_FRAMES_DEF,
  parameter int PAGE_BITS  = lfu_pkg::PAGE_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  // [15:0] page_id
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [lfu_pkg::IN_TDATA_W-1:0]  in_tdata,
  // [15:0] evicted_page, [47:16] hit_count, [79:48] fault_count
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [lfu_pkg::OUT_TDATA_W-1:0] out_tdata,
  // [0] hit, [1] evicted_valid
  output logic [lfu_pkg::OUT_TUSER_W-1:0] out_tuser,
  // frames_in_use
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [lfu_pkg::CFG_W-1:0]       cfg_data
);

  lfu_pkg::lfu_cmd_t cmd;
  lfu_pkg::lfu_sts_t sts;

  assign cfg_ready = 1'b1;

  lfu_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  lfu_dpath #(
    .NUM_FRAMES (NUM_FRAMES),
    .PAGE_BITS  (PAGE_BITS)
  ) u_dpath (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .sts        (sts),
    .in_tdata   (in_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_data   (cfg_data),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  // A taken item starts a scan, so the input closes the next cycle
  a_accept_closes: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> !in_tready)
    else $error("input still open after accepting an item");

  // A hit never reports an eviction
  a_hit_no_evict: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !(out_tuser[lfu_pkg::TUSER_HIT] && out_tuser[lfu_pkg::TUSER_EVV]))
    else $error("hit and eviction flagged together");

  // No eviction means a zero evicted page
  a_evict_page_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tuser[lfu_pkg::TUSER_EVV]) |-> (out_tdata[15:0] == '0))
    else $error("evicted page nonzero without eviction");

  // Commit happens only when the result register can take it
  a_commit_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.commit |-> (!out_tvalid || out_tready))
    else $error("result overwritten while stalled");

endmodule
